[rtl/lms_pkg.sv]
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and character codes for the link markup stripper.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_H   = 8'h48;
  localparam logic [7:0] CH_LC_H   = 8'h68;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_UC_R   = 8'h52;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  localparam logic [3:0] COLOUR_LEN = 4'd8;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       pipe_pending;
    logic [3:0] skip_left;
    logic       skip_to_pipe;
  } strip_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_end;
  } result_t;

endpackage

[rtl/link_markup_stripper_top.sv]
// ----------------------------------------------------------------------------
// link_markup_stripper_top
// Strips link markup from a chat byte stream, one byte per cycle while in_ready is high.
//
//   channel | ports                                             | dir
//   --------+---------------------------------------------------+-----
//   input   | in_valid in_ready in_byte in_last                  | in
//   result  | out_valid out_ready out_byte out_has_byte          | out
//           | out_run_last out_text_end                          |
//
// One request per cycle is taken while the result queue has two free
// slots; each request is decoded in the cycle it is taken and its 0..2
// results are written to a 4-entry queue, first result visible next cycle.
// A request giving two results hands them out one at a time.
// Synchronous active-low reset clears parser state and the queue.
// ----------------------------------------------------------------------------
module link_markup_stripper_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_run_last,
  output logic       out_text_end
);
  import lms_pkg::*;

  strip_state_t st_r, st_nxt, dec_st;
  result_t      res0, res1, rd_data;
  logic [1:0]   res_cnt, wr_cnt;
  logic         acc;
  logic         room2;

  assign in_ready = room2;
  assign acc      = in_valid && in_ready;
  assign wr_cnt   = acc ? res_cnt : 2'd0;
  assign st_nxt   = acc ? dec_st : st_r;

  lms_decode u_dec (
    .st      (st_r),
    .in_byte (in_byte),
    .in_last (in_last),
    .st_nxt  (dec_st),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  lms_out_fifo u_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0      (res0),
    .wr1      (res1),
    .wr_cnt   (wr_cnt),
    .room2    (room2),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign out_byte     = rd_data.out_byte;
  assign out_has_byte = rd_data.has_byte;
  assign out_run_last = rd_data.run_last;
  assign out_text_end = rd_data.text_end;

endmodule

[rtl/lms_decode.sv]
// ----------------------------------------------------------------------------
// lms_decode
// Per-byte markup decode: next parser state and up to two results.
// ----------------------------------------------------------------------------
module lms_decode (
  input  lms_pkg::strip_state_t st,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output lms_pkg::strip_state_t st_nxt,
  output lms_pkg::result_t      res0,
  output lms_pkg::result_t      res1,
  output logic [1:0]            res_cnt
);
  import lms_pkg::*;

  logic       emit_pipe;
  logic       emit_b;
  logic       plain_pipe;
  logic       plain_keep;
  logic       pend;
  logic       end_pipe;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [1:0] nb;

  strip_state_t s;

  assign plain_pipe = (in_byte == CH_PIPE);
  assign plain_keep = !plain_pipe && (in_byte != CH_LBRACK) && (in_byte != CH_RBRACK);

  always_comb begin
    s         = st;
    emit_pipe = 1'b0;
    emit_b    = 1'b0;
    if (st.skip_left != 4'd0) begin
      s.skip_left = st.skip_left - 4'd1;
    end else if (st.skip_to_pipe) begin
      if (plain_pipe) begin
        s.skip_to_pipe = 1'b0;
        s.pipe_pending = 1'b1;
      end
    end else if (st.pipe_pending) begin
      s.pipe_pending = 1'b0;
      if (in_byte == CH_LC_C || in_byte == CH_UC_C) begin
        s.skip_left = COLOUR_LEN;
      end else if (in_byte == CH_UC_H) begin
        s.skip_to_pipe = 1'b1;
      end else if (in_byte == CH_LC_H || in_byte == CH_LC_R || in_byte == CH_UC_R) begin
        s.pipe_pending = 1'b0;
      end else begin
        emit_pipe      = 1'b1;
        s.pipe_pending = plain_pipe;
        emit_b         = plain_keep;
      end
    end else begin
      s.pipe_pending = plain_pipe;
      emit_b         = plain_keep;
    end
  end

  assign pend     = s.pipe_pending;
  assign end_pipe = in_last && pend;

  always_comb begin
    nb = 2'd0;
    b0 = 8'd0;
    b1 = 8'd0;
    if (emit_pipe) begin
      b0 = CH_PIPE;
      nb = 2'd1;
      if (emit_b) begin
        b1 = in_byte;
        nb = 2'd2;
      end else if (end_pipe) begin
        b1 = CH_PIPE;
        nb = 2'd2;
      end
    end else if (emit_b) begin
      b0 = in_byte;
      nb = 2'd1;
      if (end_pipe) begin
        b1 = CH_PIPE;
        nb = 2'd2;
      end
    end else if (end_pipe) begin
      b0 = CH_PIPE;
      nb = 2'd1;
    end
  end

  always_comb begin
    res0.out_byte = b0;
    res0.has_byte = (nb != 2'd0);
    res0.run_last = (nb != 2'd2);
    res0.text_end = in_last && (nb != 2'd2);
    res1.out_byte = b1;
    res1.has_byte = 1'b1;
    res1.run_last = 1'b1;
    res1.text_end = in_last;
    if (nb == 2'd0) begin
      res_cnt = in_last ? 2'd1 : 2'd0;
    end else begin
      res_cnt = nb;
    end
    if (in_last) begin
      st_nxt = '0;
    end else begin
      st_nxt = s;
    end
  end

endmodule

[rtl/lms_out_fifo.sv]
// ----------------------------------------------------------------------------
// lms_out_fifo
// Result queue: takes up to two results a cycle, hands out one while rd_ready is high.
// ----------------------------------------------------------------------------
module lms_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  lms_pkg::result_t wr0,
  input  lms_pkg::result_t wr1,
  input  logic [1:0]       wr_cnt,
  output logic             room2,
  output logic             rd_valid,
  input  logic             rd_ready,
  output lms_pkg::result_t rd_data
);
  import lms_pkg::*;

  result_t          mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic [QAW-1:0]   wp1;
  logic             pop;

  assign wp1      = wp_r + QAW'(1);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign pop      = rd_valid && rd_ready;
  assign room2    = (cnt_r <= (QAW+1)'(QDEPTH - 2));

  assign wp_nxt  = wp_r + QAW'(wr_cnt);
  assign rp_nxt  = rp_r + QAW'(pop);
  assign cnt_nxt = cnt_r + (QAW+1)'(wr_cnt) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wp_r] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wp1] <= wr1;
    end
  end

endmodule
